// ----- rtl/core/fraction_arith_reduce_unit_defines.svh -----
// Assertion macros shared by the fraction unit RTL.
// Depends on nothing; included by modules that assert.
`ifndef FRACTION_ARITH_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FAR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("fail");
`define FAR_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("fail");
`else
`define FAR_ASSERT(lbl, clk, rstn, prop)
`define FAR_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- rtl/core/far_pkg.sv -----
// Package for the fraction arithmetic unit: operation codes and job word.
// No dependencies.
package far_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;
  localparam int unsigned RawW = 64;
  typedef struct packed {
    logic [RawW-1:0] num;
    logic [RawW-1:0] den;
  } job_t;
endpackage

// ----- rtl/core/far_front.sv -----
// Front end: accepts a word, forms raw numerator and denominator by cross-multiplication.
// Depends on far_pkg.
`include "fraction_arith_reduce_unit_defines.svh"
module far_front #(
  parameter int unsigned OperandWidth = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              operation_i,
  input  logic [OperandWidth-1:0] a_num_i,
  input  logic [OperandWidth-1:0] a_den_i,
  input  logic [OperandWidth-1:0] b_num_i,
  input  logic [OperandWidth-1:0] b_den_i,
  input  logic                    q_full_i,
  output logic                    busy_o,
  output logic                    push_o,
  output far_pkg::job_t           job_o
);
  import far_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0, S_MUL = 2'd1, S_SUM = 2'd2;
  localparam int unsigned ProdW = 2 * OperandWidth;
  logic [1:0] st_q, st_d;
  logic [1:0] op_q;
  logic [OperandWidth-1:0] an_q, ad_q, bn_q, bd_q, m1, m2;
  logic signed [ProdW-1:0] p0_w, p1_w, p2_w;
  logic [RawW-1:0] p0_q, p1_q, p2_q;
  logic [RawW-1:0] p0_d, p1_d, p2_d;

  assign busy_o = (st_q != S_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (start_i) st_d = S_MUL;
      S_MUL:  st_d = S_SUM;
      S_SUM:  if (!q_full_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  assign m1 = (op_q == OP_DIV) ? bn_q : bd_q;
  assign m2 = (op_q == OP_MUL) ? bn_q : bd_q;
  assign p0_w = $signed(an_q) * $signed(m2);
  assign p1_w = $signed(ad_q) * $signed(bn_q);
  assign p2_w = $signed(ad_q) * $signed(m1);
  assign p0_d = RawW'(p0_w);
  assign p1_d = RawW'(p1_w);
  assign p2_d = RawW'(p2_w);

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      op_q <= operation_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (st_q == S_MUL) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  always_comb begin
    case (op_q)
      OP_ADD:  job_o.num = p0_q + p1_q;
      OP_SUB:  job_o.num = p0_q - p1_q;
      default: job_o.num = p0_q;
    endcase
    job_o.den = p2_q;
  end
  assign push_o = (st_q == S_SUM) && !q_full_i;

  `FAR_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_o && q_full_i)
  `FAR_ASSERT(a_push_idle, clk_i, rst_ni, push_o |=> !busy_o)
  `FAR_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o)
endmodule

// ----- rtl/core/far_back.sv -----
// Back end: binary GCD over magnitudes, then two restoring divisions; a zero part skips both.
// Depends on far_pkg.
`include "fraction_arith_reduce_unit_defines.svh"
module far_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  far_pkg::job_t job_i,
  output logic          pop_o,
  output logic          valid_o,
  output logic [32:0]   res_num_o,
  output logic [31:0]   res_den_o,
  output logic          zero_den_o
);
  import far_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_GCD = 3'd1, S_DIVN = 3'd2,
                         S_DIVD = 3'd3, S_OUT = 3'd4;
  localparam int unsigned CntW = $clog2(RawW + 1);
  logic [2:0] st_q, st_d;
  logic [RawW-1:0] num_q, den_q, x_q, y_q, g_q;
  logic [CntW-1:0] sh_q, cnt_q;
  logic [RawW-1:0] quo_q, rem_q, dvd_q;
  logic [RawW:0] trial;
  logic [RawW-1:0] mn, md;
  logic first_q;

  assign mn = num_q[RawW-1] ? -num_q : num_q;
  assign md = den_q[RawW-1] ? -den_q : den_q;
  assign trial = {rem_q, dvd_q[RawW-1]} - {1'b0, g_q};
  assign pop_o = (st_q == S_IDLE) && q_valid_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (q_valid_i) st_d = S_GCD;
      S_GCD:  if (num_q == '0 || den_q == '0) st_d = S_OUT;
              else if (!first_q && x_q == y_q) st_d = S_DIVN;
      S_DIVN: if (cnt_q == CntW'(RawW)) st_d = S_DIVD;
      S_DIVD: if (cnt_q == CntW'(RawW)) st_d = S_OUT;
      S_OUT:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // gcd (strip common twos, subtract-and-shift; first cycle loads magnitudes), divisions
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        num_q <= job_i.num;
        den_q <= job_i.den;
        first_q <= 1'b1;
        sh_q <= '0;
      end
      S_GCD: begin
        first_q <= 1'b0;
        if (first_q) begin
          x_q <= mn;
          y_q <= md;
        end else if (x_q == y_q) begin
          g_q <= x_q << sh_q;
          cnt_q <= '0;
          dvd_q <= mn;
          rem_q <= '0;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          sh_q <= sh_q + 1'b1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q > y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        if (cnt_q == CntW'(RawW)) begin
          if (st_q == S_DIVN) begin
            num_q <= num_q[RawW-1] ? -quo_q : quo_q;
            dvd_q <= md;
            rem_q <= '0;
            cnt_q <= '0;
          end else begin
            den_q <= den_q[RawW-1] ? -quo_q : quo_q;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          dvd_q <= dvd_q << 1;
          if (!trial[RawW]) begin
            rem_q <= trial[RawW-1:0];
            quo_q <= {quo_q[RawW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[RawW-2:0], dvd_q[RawW-1]};
            quo_q <= {quo_q[RawW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign valid_o = (st_q == S_OUT);
  assign res_num_o = num_q[32:0];
  assign res_den_o = den_q[31:0];
  assign zero_den_o = (den_q == '0);

  `FAR_ASSERT(a_out_pulse, clk_i, rst_ni, valid_o |=> !valid_o)
  `FAR_ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, pop_o && st_q != S_IDLE)
  `FAR_ASSERT(a_cnt_rng, clk_i, rst_ni, cnt_q <= CntW'(RawW) || st_q == S_IDLE || st_q == S_GCD)
endmodule

// ----- rtl/core/fraction_arith_reduce_unit.sv -----
// Top level of the fraction arithmetic unit: front, one-word queue, back.
// Depends on far_pkg, far_front, far_back.
// Usage: drive operation_i and the four operands with start while busy is
// low; the word is taken at that edge. The front multiplies out the raw
// numerator and denominator, first registering the operands, then the
// products, and hands them to a one-word queue once it is not full, so a
// second word can be taken while the back is still reducing. The back
// finds the gcd of the magnitudes with a binary gcd, one step per cycle,
// then divides each part by it with a 64-bit restoring divider, twice.
// A zero part skips reduction. The back reduces one word at a time and
// takes the next word from the queue only when it is idle.
// valid_o is high for one cycle with res_num_o, res_den_o and zero_den_o;
// the receiver cannot stall, results are never held back.
// Reset clears front, queue and back control; nothing is in flight after it.
module fraction_arith_reduce_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-1:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-1:0] b_den_i,
  output logic                     valid_o,
  output logic [32:0]              res_num_o,
  output logic [31:0]              res_den_o,
  output logic                     zero_den_o
);
  import far_pkg::*;
  logic push, pop, full_q;
  job_t fjob, qjob_q;

  far_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
    .clk_i, .rst_ni, .start_i(start), .operation_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .q_full_i(full_q), .busy_o(busy), .push_o(push),
    .job_o(fjob)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (push) begin
      full_q <= 1'b1;
    end else if (pop) begin
      full_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) qjob_q <= fjob;
  end

  far_back u_back (
    .clk_i, .rst_ni, .q_valid_i(full_q), .job_i(qjob_q), .pop_o(pop),
    .valid_o, .res_num_o, .res_den_o, .zero_den_o
  );
endmodule

// ----- tb/far_result_check.sv -----
// Result checker for the fraction arithmetic unit: predicts the reduced fraction
// of every accepted word and compares each result strobe with the oldest prediction.
// Depends on far_pkg.
`timescale 1ns / 100ps

module far_result_check
  import far_pkg::*;
#(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         busy_i,
  input  logic [1:0]   operation_i,
  input  logic [W-1:0] a_num_i,
  input  logic [W-1:0] a_den_i,
  input  logic [W-1:0] b_num_i,
  input  logic [W-1:0] b_den_i,
  input  logic         valid_i,
  input  logic [32:0]  res_num_i,
  input  logic [31:0]  res_den_i,
  input  logic         zero_den_i,
  output int           errors_o,
  output int           pending_o,
  output int           results_o,
  output int           zero_den_seen_o
);

  typedef struct packed {
    logic [32:0] num;
    logic [31:0] den;
    logic        zero_den;
  } frac_t;

  frac_t reduced_q[$];

  function automatic frac_t reduce_fraction(op_e op, logic [W-1:0] an, logic [W-1:0] ad,
                                            logic [W-1:0] bn, logic [W-1:0] bd);
    longint      san, sad, sbn, sbd, num, den;
    logic [63:0] x, y, t;
    frac_t       r;
    san = longint'($signed(an));
    sad = longint'($signed(ad));
    sbn = longint'($signed(bn));
    sbd = longint'($signed(bd));
    case (op)
      OP_ADD: begin
        num = san * sbd + sad * sbn;
        den = sad * sbd;
      end
      OP_SUB: begin
        num = san * sbd - sad * sbn;
        den = sad * sbd;
      end
      OP_MUL: begin
        num = san * sbn;
        den = sad * sbd;
      end
      default: begin
        num = san * sbd;
        den = sad * sbn;
      end
    endcase
    if (num != 0 && den != 0) begin
      x = (num < 0) ? -num : num;
      y = (den < 0) ? -den : den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      if (x > 1) begin
        num = num / longint'(x);
        den = den / longint'(x);
      end
    end
    r.num      = num[32:0];
    r.den      = den[31:0];
    r.zero_den = (den == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frac_t e;
    if (!rst_ni) begin
      reduced_q.delete();
      errors_o        <= 0;
      results_o       <= 0;
      zero_den_seen_o <= 0;
    end else begin
      if (valid_i) begin
        results_o <= results_o + 1;
        if (zero_den_i) zero_den_seen_o <= zero_den_seen_o + 1;
        if (reduced_q.size() == 0) begin
          if (errors_o < 10) $display("check: result with no word pending");
          errors_o <= errors_o + 1;
        end else begin
          e = reduced_q.pop_front();
          if (e.num !== res_num_i || e.den !== res_den_i || e.zero_den !== zero_den_i) begin
            if (errors_o < 10)
              $display("check: mismatch exp %0d/%0d z%0b got %0d/%0d z%0b",
                       $signed(e.num), $signed(e.den), e.zero_den,
                       $signed(res_num_i), $signed(res_den_i), zero_den_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        reduced_q.push_back(reduce_fraction(op_e'(operation_i), a_num_i, a_den_i,
                                            b_num_i, b_den_i));
    end
  end

  assign pending_o = reduced_q.size();

endmodule

// ----- tb/tb.sv -----
// Testbench top for fraction_arith_reduce_unit: directed and random words in bursts,
// checked by far_result_check. Depends on far_pkg, far_result_check and the unit.
`timescale 1ns / 100ps

module tb;
  import far_pkg::*;

  localparam int W        = 16;
  localparam int N_RANDOM = 1130;
  localparam int LIMIT    = 1500000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [1:0]   operation_i = '0;
  logic [W-1:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic         valid_o, zero_den_o;
  logic [32:0]  res_num_o;
  logic [31:0]  res_den_o;
  int           errors, pending, results, zero_dens;
  int           words_sent = 0;
  int           cycles = 0;

  always #10 clk_i = ~clk_i;

  fraction_arith_reduce_unit #(.OPERAND_WIDTH(W)) dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .valid_o, .res_num_o, .res_den_o, .zero_den_o
  );

  far_result_check #(.W(W)) u_check (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .operation_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .valid_i(valid_o), .res_num_i(res_num_o), .res_den_i(res_den_o),
    .zero_den_i(zero_den_o), .errors_o(errors), .pending_o(pending), .results_o(results),
    .zero_den_seen_o(zero_dens)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // start stays high across a burst; lowered only when the burst ends
  task automatic send_word(op_e op, logic [W-1:0] an, logic [W-1:0] ad,
                           logic [W-1:0] bn, logic [W-1:0] bd);
    start       <= 1'b1;
    operation_i <= op;
    a_num_i     <= an;
    a_den_i     <= ad;
    b_num_i     <= bn;
    b_den_i     <= bd;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk_i);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0) @(posedge clk_i);
  endtask

  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3, 4:    return W'($signed($urandom_range(0, 24)) - 12);
      5, 6:    return W'($urandom_range(0, 255)) ^ {W{$urandom_range(0, 1) == 1}};
      default: return W'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_word(OP_MUL, 16'd4, 16'd6, 16'd3, 16'd8);
    send_word(OP_DIV, 16'd2, 16'd3, 16'd4, 16'd9);
    send_word(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_word(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_DIV, 16'h8000, 16'hffff, 16'h8000, 16'h0001);
    send_word(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_MUL, 16'h0000, 16'd6, 16'd5, 16'd1);
    send_word(OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
    send_word(OP_ADD, 16'd1, 16'd0, 16'd2, 16'd3);
    send_word(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd2);
    send_word(OP_MUL, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(OP_ADD, -16'sd6, 16'd4, 16'd2, -16'sd8);
    send_word(OP_DIV, -16'sd9, -16'sd12, 16'd3, -16'sd4);
    send_word(OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(OP_SUB, 16'h7fff, 16'h0001, 16'h8000, 16'h0001);
    send_word(OP_DIV, 16'hffff, 16'h5555, 16'haaaa, 16'h0001);
    send_word(OP_ADD, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    end_burst();
    while (pending != 0) @(posedge clk_i);

    while (words_sent < N_RANDOM + 20) begin
      burst = $urandom_range(1, 8);
      repeat (burst)
        send_word(op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
      end_burst();
      if ($urandom_range(0, 49) == 0)
        while (pending != 0) @(posedge clk_i);
    end

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("tb: %0d words sent, %0d results checked, %0d with zero denominator",
             words_sent, results, zero_dens);
    $display("tb: all four operations, operand extremes, zero parts and signs exercised");
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
